// File: hw/rtl/spl_pkg.sv
// shared types, widths and codes for the sorted priority list
package spl_pkg;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int ID_W   = 16;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // default sizing
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_BITS  = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_SORTED = 3'd0;
  localparam logic [OP_W-1:0] OP_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP    = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             clear;
    logic             scan;
    logic             ins;
    logic             del;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } spl_ctl_t;

endpackage

// File: hw/rtl/spl_if.sv
// request and response channel interfaces of the sorted priority list
interface spl_req_if;
  import spl_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [ID_W-1:0]  entry_id;
  logic [KEY_W-1:0] entry_key;
  modport source (output valid, op, entry_id, entry_key, input ready);
  modport sink   (input valid, op, entry_id, entry_key, output ready);
endinterface

interface spl_rsp_if;
  import spl_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [KEY_W-1:0]  out_key;
  logic [OCC_W-1:0]  occupancy;
  modport source (output valid, status, out_id, out_key, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_key, occupancy, output ready);
endinterface

// File: hw/rtl/spl_cell.sv
// one list slot: holds an entry, finds its own match and shifts with its neighbors
module spl_cell #(
  parameter int ID_BITS = spl_pkg::DEF_ID_BITS,
  parameter bit HEAD    = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spl_pkg::spl_ctl_t        ctl,
  input  logic [ID_BITS-1:0]       cmp_id,
  input  logic                     occ,
  input  logic                     occ_prev,
  input  logic                     occ_next,
  input  logic [ID_BITS-1:0]       prev_id,
  input  logic [spl_pkg::KEY_W-1:0] prev_key,
  input  logic [ID_BITS-1:0]       next_id,
  input  logic [spl_pkg::KEY_W-1:0] next_key,
  input  logic                     seen_in,
  input  logic                     fnd_in,
  input  logic [ID_BITS-1:0]       fid_in,
  input  logic [spl_pkg::KEY_W-1:0] fkey_in,
  output logic [ID_BITS-1:0]       id_q,
  output logic [spl_pkg::KEY_W-1:0] key_q,
  output logic                     fwd_out,
  output logic                     fnd_q,
  output logic [ID_BITS-1:0]       fid_q,
  output logic [spl_pkg::KEY_W-1:0] fkey_q
);
  import spl_pkg::*;

  logic seen;
  logic hit;

  // local match for the current operation
  always_comb begin
    hit = 1'b0;
    case (ctl.op)
      OP_SORTED: begin
        if (HEAD) begin
          hit = !occ || (key_q >= ctl.key);
        end else begin
          hit = (occ && (prev_key <= ctl.key) && (key_q > ctl.key)) ||
                (!occ && occ_prev && (prev_key <= ctl.key)) ||
                (occ && !occ_next && (key_q > ctl.key));
        end
      end
      OP_BACK:   hit = !occ;
      OP_FRONT:  hit = HEAD;
      OP_POP:    hit = HEAD && occ;
      OP_REMOVE: hit = occ && (id_q == cmp_id);
      default:   hit = 1'b0;
    endcase
  end

  // a match at or before this slot travels toward the tail
  assign fwd_out = seen | hit;

  // search chain flags
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= 1'b0;
      fnd_q <= 1'b0;
    end else if (ctl.clear) begin
      seen  <= 1'b0;
      fnd_q <= 1'b0;
    end else if (ctl.scan) begin
      seen  <= seen_in;
      fnd_q <= hit | fnd_in;
    end
  end

  // first matching entry travels toward the head
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      fid_q  <= hit ? id_q : fid_in;
      fkey_q <= hit ? key_q : fkey_in;
    end
  end

  // slot contents: open a gap or close one
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (seen) begin
        id_q  <= prev_id;
        key_q <= prev_key;
      end else if (hit) begin
        id_q  <= cmp_id;
        key_q <= ctl.key;
      end
    end else if (ctl.del && (seen || hit)) begin
      id_q  <= next_id;
      key_q <= next_key;
    end
  end

endmodule

// File: hw/rtl/sorted_priority_list.sv
// sorted priority list: a row of slot cells run by a small sequencer
// flow: accept, then a scan state that searches the chain, then a done state that waits for a free
// result register, commits and registers the result; a new request is taken only when idle again.
// The search passes one cell per cycle along the chain, so the scan follows the number of entries held
// reset: list empty, no result pending; slot contents stay undefined until written
module sorted_priority_list #(
  parameter int CAPACITY = spl_pkg::DEF_CAPACITY,
  parameter int ID_BITS  = spl_pkg::DEF_ID_BITS
) (
  input logic      clk,
  input logic      rst,
  spl_req_if.sink  req,
  spl_rsp_if.source rsp
);
  import spl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   scnt;
  logic [OP_W-1:0]    op_r;
  logic [ID_BITS-1:0] id_r;
  logic [KEY_W-1:0]   key_r;

  logic               accept;
  logic               done_go;
  logic               is_ins;
  logic               is_del;
  logic               full;
  logic               do_ins;
  logic               do_del;
  logic [STAT_W-1:0]  st_next;
  spl_ctl_t           ctl;

  logic              out_valid;
  logic [STAT_W-1:0] st_r;
  logic [ID_W-1:0]   oid_r;
  logic [KEY_W-1:0]  okey_r;
  logic [OCC_W-1:0]  occ_r;

  logic [ID_BITS-1:0] id_a   [CAPACITY];
  logic [KEY_W-1:0]   key_a  [CAPACITY];
  logic               fwd_a  [CAPACITY];
  logic               fnd_a  [CAPACITY];
  logic [ID_BITS-1:0] fid_a  [CAPACITY];
  logic [KEY_W-1:0]   fkey_a [CAPACITY];
  logic               occ_a  [CAPACITY];

  // handshake
  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign done_go   = (state == S_DONE) && (!out_valid || rsp.ready);

  // operation decode and outcome
  always_comb begin
    is_ins     = op_r inside {OP_SORTED, OP_BACK, OP_FRONT};
    is_del     = op_r inside {OP_POP, OP_REMOVE};
    full       = (count == CNT_W'(CAPACITY));
    do_ins     = is_ins && !full;
    do_del     = is_del && fnd_a[0];
    st_next    = ST_OK;
    count_next = count;
    if (is_ins && full) begin
      st_next = ST_FULL;
    end else if (is_del && !fnd_a[0]) begin
      st_next = ST_EMPTY;
    end
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  // broadcast to the cells
  always_comb begin
    ctl.clear = accept;
    ctl.scan  = (state == S_SCAN);
    ctl.ins   = done_go && do_ins;
    ctl.del   = done_go && do_del;
    ctl.op    = op_r;
    ctl.key   = key_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      scnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          scnt <= '0;
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scnt <= scnt + CNT_W'(1);
          if (scnt == count) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_go) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latched request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= req.op;
      id_r  <= ID_BITS'(req.entry_id);
      key_r <= req.entry_key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      st_r   <= st_next;
      oid_r  <= do_del ? ID_W'(fid_a[0]) : '0;
      okey_r <= do_del ? fkey_a[0] : '0;
      occ_r  <= OCC_W'(count_next);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = st_r;
  assign rsp.out_id    = oid_r;
  assign rsp.out_key   = okey_r;
  assign rsp.occupancy = occ_r;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               occ_prev;
    logic               occ_next;
    logic [ID_BITS-1:0] prev_id;
    logic [KEY_W-1:0]   prev_key;
    logic [ID_BITS-1:0] next_id;
    logic [KEY_W-1:0]   next_key;
    logic               seen_in;
    logic               fnd_in;
    logic [ID_BITS-1:0] fid_in;
    logic [KEY_W-1:0]   fkey_in;

    assign occ_a[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign occ_prev = 1'b0;
      assign prev_id  = '0;
      assign prev_key = '0;
      assign seen_in  = 1'b0;
    end else begin : g_body
      assign occ_prev = occ_a[i-1];
      assign prev_id  = id_a[i-1];
      assign prev_key = key_a[i-1];
      assign seen_in  = fwd_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign occ_next = 1'b0;
      assign next_id  = '0;
      assign next_key = '0;
      assign fnd_in   = 1'b0;
      assign fid_in   = '0;
      assign fkey_in  = '0;
    end else begin : g_mid
      assign occ_next = occ_a[i+1];
      assign next_id  = id_a[i+1];
      assign next_key = key_a[i+1];
      assign fnd_in   = fnd_a[i+1];
      assign fid_in   = fid_a[i+1];
      assign fkey_in  = fkey_a[i+1];
    end

    spl_cell #(
      .ID_BITS (ID_BITS),
      .HEAD    (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cmp_id   (id_r),
      .occ      (occ_a[i]),
      .occ_prev (occ_prev),
      .occ_next (occ_next),
      .prev_id  (prev_id),
      .prev_key (prev_key),
      .next_id  (next_id),
      .next_key (next_key),
      .seen_in  (seen_in),
      .fnd_in   (fnd_in),
      .fid_in   (fid_in),
      .fkey_in  (fkey_in),
      .id_q     (id_a[i]),
      .key_q    (key_a[i]),
      .fwd_out  (fwd_a[i]),
      .fnd_q    (fnd_a[i]),
      .fid_q    (fid_a[i]),
      .fkey_q   (fkey_a[i])
    );
  end

endmodule
